/* src/tad_pkg.sv */
package tad_pkg;

	localparam int MAG_BITS      = 12;
	localparam int CORDIC_STAGES = 24;
	localparam int ROOT_FRAC     = 8;
	localparam int SQ_BITS       = 2 * MAG_BITS + 1 + 2 * ROOT_FRAC;
	localparam int ROOT_BITS     = (SQ_BITS + 1) / 2;
	localparam int RAD_BITS      = 2 * ROOT_BITS;
	localparam int REM_BITS      = ROOT_BITS + 2;
	localparam int CW            = ROOT_BITS + 3;
	localparam int ZW            = 27;
	localparam int IDX_BITS      = 5;
	localparam int DEG_BITS      = 7;
	localparam int DIG_BITS      = 4;
	localparam int SCALE_STAGES  = 4;
	localparam int LATENCY       = 2 + ROOT_BITS + CORDIC_STAGES + SCALE_STAGES;
	localparam logic [DEG_BITS-1:0] MAX_DEG = 7'd90;

	typedef struct packed {
		logic [RAD_BITS-1:0]  rad;
		logic [REM_BITS-1:0]  rem;
		logic [ROOT_BITS-1:0] root;
		logic [MAG_BITS-1:0]  num;
	} sq_t;

	typedef struct packed {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [ZW-1:0] z;
		logic                 num_zero;
		logic                 den_zero;
	} cd_t;

	// atan(2^-i) in radians, 24 fractional bits, rounded to nearest.
	function automatic logic [ZW-1:0] atan_q24(input logic [IDX_BITS-1:0] idx);
		logic [ZW-1:0] v;
		case (idx)
			5'd0:  v = ZW'(13176795);
			5'd1:  v = ZW'(7778716);
			5'd2:  v = ZW'(4110060);
			5'd3:  v = ZW'(2086331);
			5'd4:  v = ZW'(1047214);
			5'd5:  v = ZW'(524117);
			5'd6:  v = ZW'(262123);
			5'd7:  v = ZW'(131069);
			5'd8:  v = ZW'(65536);
			5'd9:  v = ZW'(32768);
			5'd10: v = ZW'(16384);
			5'd11: v = ZW'(8192);
			5'd12: v = ZW'(4096);
			5'd13: v = ZW'(2048);
			5'd14: v = ZW'(1024);
			5'd15: v = ZW'(512);
			5'd16: v = ZW'(256);
			5'd17: v = ZW'(128);
			5'd18: v = ZW'(64);
			5'd19: v = ZW'(32);
			5'd20: v = ZW'(16);
			5'd21: v = ZW'(8);
			5'd22: v = ZW'(4);
			5'd23: v = ZW'(2);
			5'd24: v = ZW'(1);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

/* src/tad_sqrt_cell.sv */
module tad_sqrt_cell
	import tad_pkg::*;
(
	input  logic clk,
	input  sq_t  din,
	output sq_t  dout
);

	logic [REM_BITS-1:0] cur;
	logic [REM_BITS-1:0] trial;
	sq_t                 nxt;

	// One root bit per cell: bring down two radicand bits, try to subtract 4q+1.
	always_comb begin
		cur   = {din.rem[REM_BITS-3:0], din.rad[RAD_BITS-1 -: 2]};
		trial = {din.root, 2'b01};
		nxt       = din;
		nxt.rad   = {din.rad[RAD_BITS-3:0], 2'b00};
		if (cur >= trial) begin
			nxt.rem  = cur - trial;
			nxt.root = {din.root[ROOT_BITS-2:0], 1'b1};
		end else begin
			nxt.rem  = cur;
			nxt.root = {din.root[ROOT_BITS-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		dout <= nxt;
	end

endmodule

/* src/tad_cordic_cell.sv */
module tad_cordic_cell
	import tad_pkg::*;
(
	input  logic                clk,
	input  logic [IDX_BITS-1:0] stage,
	input  cd_t                 din,
	output cd_t                 dout
);

	logic signed [CW-1:0] dx;
	logic signed [CW-1:0] dy;
	logic signed [ZW-1:0] ang;
	cd_t                  nxt;

	always_comb begin
		dx  = din.y >>> stage;
		dy  = din.x >>> stage;
		ang = $signed(atan_q24(stage));
		nxt = din;
		if (!din.y[CW-1]) begin
			nxt.x = din.x + dx;
			nxt.y = din.y - dy;
			nxt.z = din.z + ang;
		end else begin
			nxt.x = din.x - dx;
			nxt.y = din.y + dy;
			nxt.z = din.z - ang;
		end
	end

	always_ff @(posedge clk) begin
		dout <= nxt;
	end

endmodule

/* src/tad_scale.sv */
module tad_scale
	import tad_pkg::*;
(
	input  logic                clk,
	input  cd_t                 din,
	output logic [DEG_BITS-1:0] deg,
	output logic [DIG_BITS-1:0] ones,
	output logic [DIG_BITS-1:0] tens
);

	logic [39:0]          prod;
	logic [15:0]          t_s1;
	logic                 sat_s1;
	logic [24:0]          rprod;
	logic [15:0]          t_s2;
	logic [7:0]           q0_s2;
	logic                 sat_s2;
	logic [16:0]          rem;
	logic [7:0]           q1;
	logic [DEG_BITS-1:0]  deg_s3;
	logic [14:0]          tprod;
	logic [DIG_BITS-1:0]  tens_c;

	// Degrees are Z * 9000 / (157 * 2^24): shift out 2^24 first, then divide by 157.
	assign prod  = {14'd0, din.z[25:0]} * 40'd9000;
	assign rprod = {9'd0, t_s1} * 25'd417;
	assign rem   = {1'b0, t_s2} - 17'({9'd0, q0_s2} * 17'd157);
	assign q1    = q0_s2 + 8'((rem >= 17'd157) ? 1 : 0);
	assign tprod = {8'd0, deg_s3} * 15'd205;
	assign tens_c = tprod[14:11];

	always_ff @(posedge clk) begin
		sat_s1 <= !din.num_zero && din.den_zero;
		if (din.num_zero || din.den_zero || din.z <= 0)
			t_s1 <= '0;
		else
			t_s1 <= prod[39:24];

		sat_s2 <= sat_s1;
		t_s2   <= t_s1;
		q0_s2  <= rprod[23:16];

		if (sat_s2 || q1 > {1'b0, MAX_DEG})
			deg_s3 <= MAX_DEG;
		else
			deg_s3 <= q1[DEG_BITS-1:0];

		deg  <= deg_s3;
		tens <= tens_c;
		ones <= DIG_BITS'(deg_s3 - DEG_BITS'({3'd0, tens_c} * 7'd10));
	end

endmodule

/* src/tilt_angle_to_decimal_digits_core.sv */
// Channel  | Ports                                    | Transfer
// ---------+------------------------------------------+---------------------------
// input    | start, busy, x_mag, y_mag, z_mag         | edge with start && !busy
// result   | done, angle_*_deg, x_*, y_* digits       | edge ending the done cycle
//
// Fully pipelined: one sample set per clock, busy is always low.
// The pipeline runs through squares, sums, 21 square-root cells (one root bit each),
// 24 CORDIC cells (one rotation each) and 4 scaling and digit stages.
// Reset clears only the valid chain; results appear one per accepted sample.
// The receiver cannot stall, so nothing in the pipeline ever holds.
module tilt_angle_to_decimal_digits_core
	import tad_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic [MAG_BITS-1:0] x_mag,
	input  logic [MAG_BITS-1:0] y_mag,
	input  logic [MAG_BITS-1:0] z_mag,
	output logic                done,
	output logic [DEG_BITS-1:0] angle_x_deg,
	output logic [DEG_BITS-1:0] angle_y_deg,
	output logic [DIG_BITS-1:0] x_ones,
	output logic [DIG_BITS-1:0] x_tens,
	output logic [DIG_BITS-1:0] x_hundreds,
	output logic [DIG_BITS-1:0] x_thousands,
	output logic [DIG_BITS-1:0] y_ones,
	output logic [DIG_BITS-1:0] y_tens,
	output logic [DIG_BITS-1:0] y_hundreds,
	output logic [DIG_BITS-1:0] y_thousands
);

	logic [LATENCY-1:0]      vld_q;
	logic [2*MAG_BITS-1:0]   xx_s1, yy_s1, zz_s1;
	logic [MAG_BITS-1:0]     xn_s1, yn_s1, xn_s2, yn_s2;
	logic [2*MAG_BITS:0]     sumx_s2, sumy_s2;
	sq_t                     sqx [ROOT_BITS+1];
	sq_t                     sqy [ROOT_BITS+1];
	cd_t                     cdx [CORDIC_STAGES+1];
	cd_t                     cdy [CORDIC_STAGES+1];

	assign busy = 1'b0;
	assign done = vld_q[LATENCY-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else
			vld_q <= {vld_q[LATENCY-2:0], start};
	end

	always_ff @(posedge clk) begin
		xx_s1   <= x_mag * x_mag;
		yy_s1   <= y_mag * y_mag;
		zz_s1   <= z_mag * z_mag;
		xn_s1   <= x_mag;
		yn_s1   <= y_mag;
		sumx_s2 <= {1'b0, yy_s1} + {1'b0, zz_s1};
		sumy_s2 <= {1'b0, xx_s1} + {1'b0, zz_s1};
		xn_s2   <= xn_s1;
		yn_s2   <= yn_s1;
	end

	// Radicand is the sum of squares with 16 fractional bits.
	always_comb begin
		sqx[0].rad  = RAD_BITS'({sumx_s2, {(2*ROOT_FRAC){1'b0}}});
		sqx[0].rem  = '0;
		sqx[0].root = '0;
		sqx[0].num  = xn_s2;
		sqy[0].rad  = RAD_BITS'({sumy_s2, {(2*ROOT_FRAC){1'b0}}});
		sqy[0].rem  = '0;
		sqy[0].root = '0;
		sqy[0].num  = yn_s2;
	end

	for (genvar k = 0; k < ROOT_BITS; k++) begin : g_sqrt
		tad_sqrt_cell u_sx (.clk(clk), .din(sqx[k]), .dout(sqx[k+1]));
		tad_sqrt_cell u_sy (.clk(clk), .din(sqy[k]), .dout(sqy[k+1]));
	end

	always_comb begin
		cdx[0].x        = $signed({{(CW-ROOT_BITS){1'b0}}, sqx[ROOT_BITS].root});
		cdx[0].y        = $signed({{(CW-MAG_BITS-ROOT_FRAC){1'b0}}, sqx[ROOT_BITS].num,
			{ROOT_FRAC{1'b0}}});
		cdx[0].z        = '0;
		cdx[0].num_zero = (sqx[ROOT_BITS].num == '0);
		cdx[0].den_zero = (sqx[ROOT_BITS].root == '0);
		cdy[0].x        = $signed({{(CW-ROOT_BITS){1'b0}}, sqy[ROOT_BITS].root});
		cdy[0].y        = $signed({{(CW-MAG_BITS-ROOT_FRAC){1'b0}}, sqy[ROOT_BITS].num,
			{ROOT_FRAC{1'b0}}});
		cdy[0].z        = '0;
		cdy[0].num_zero = (sqy[ROOT_BITS].num == '0);
		cdy[0].den_zero = (sqy[ROOT_BITS].root == '0);
	end

	for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
		tad_cordic_cell u_cx (.clk(clk), .stage(IDX_BITS'(k)), .din(cdx[k]), .dout(cdx[k+1]));
		tad_cordic_cell u_cy (.clk(clk), .stage(IDX_BITS'(k)), .din(cdy[k]), .dout(cdy[k+1]));
	end

	tad_scale u_scx (
		.clk (clk),
		.din (cdx[CORDIC_STAGES]),
		.deg (angle_x_deg),
		.ones(x_ones),
		.tens(x_tens)
	);

	tad_scale u_scy (
		.clk (clk),
		.din (cdy[CORDIC_STAGES]),
		.deg (angle_y_deg),
		.ones(y_ones),
		.tens(y_tens)
	);

	// The angle never exceeds 90, so the upper digits are constant.
	assign x_hundreds  = '0;
	assign x_thousands = '0;
	assign y_hundreds  = '0;
	assign y_thousands = '0;

endmodule

/* src/tad_checker.sv */
module tad_checker
	import tad_pkg::*;
(
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input logic                done,
	input logic [DEG_BITS-1:0] angle_x_deg,
	input logic [DEG_BITS-1:0] angle_y_deg,
	input logic [DIG_BITS-1:0] x_ones,
	input logic [DIG_BITS-1:0] x_tens,
	input logic [DIG_BITS-1:0] y_ones,
	input logic [DIG_BITS-1:0] y_tens
);

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("result strobe missing after fixed latency");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (angle_x_deg <= MAX_DEG && angle_y_deg <= MAX_DEG))
		else $error("angle above 90 degrees");

	a_digits_x: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (x_ones <= 4'd9 && 7'({3'd0, x_tens} * 7'd10 + {3'd0, x_ones}) == angle_x_deg))
		else $error("x digits do not match x angle");

	a_digits_y: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (y_ones <= 4'd9 && 7'({3'd0, y_tens} * 7'd10 + {3'd0, y_ones}) == angle_y_deg))
		else $error("y digits do not match y angle");

endmodule

bind tilt_angle_to_decimal_digits_core tad_checker u_tad_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.done       (done),
	.angle_x_deg(angle_x_deg),
	.angle_y_deg(angle_y_deg),
	.x_ones     (x_ones),
	.x_tens     (x_tens),
	.y_ones     (y_ones),
	.y_tens     (y_tens)
);

/* tb/testbench.sv */
module testbench
	import tad_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 20 * LATENCY + 2000;

	typedef struct packed {
		logic [MAG_BITS-1:0] x;
		logic [MAG_BITS-1:0] y;
		logic [MAG_BITS-1:0] z;
	} sample_t;

	typedef struct packed {
		logic [DEG_BITS-1:0] ax;
		logic [DEG_BITS-1:0] ay;
		logic [DIG_BITS-1:0] x1, x10, x100, x1000;
		logic [DIG_BITS-1:0] y1, y10, y100, y1000;
	} tilt_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [MAG_BITS-1:0] x_mag = '0, y_mag = '0, z_mag = '0;
	logic busy, done;
	logic [DEG_BITS-1:0] angle_x_deg, angle_y_deg;
	logic [DIG_BITS-1:0] x_ones, x_tens, x_hundreds, x_thousands;
	logic [DIG_BITS-1:0] y_ones, y_tens, y_hundreds, y_thousands;

	sample_t pending_samples[$];
	tilt_t   expected_tilts[$];
	int      send_idle_pct = 0;
	bit      stim_done = 1'b0;
	int      errors = 0;
	int      quiet_cycles = 0;

	tilt_angle_to_decimal_digits_core u_top (.*);

	always #5 clk = ~clk;

	function automatic longint unsigned isqrt(longint unsigned v);
		longint unsigned res = 0;
		longint unsigned b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic int tilt_of(longint num, longint a, longint b);
		longint cx, cy, cz, dx, dy, d;
		longint unsigned r;
		longint tq[25] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123,
			131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
			16, 8, 4, 2, 1};
		cz = 0;
		if (num == 0) return 0;
		r = isqrt((a * a + b * b) << 16);
		if (r == 0) return 90;
		cx = longint'(r);
		cy = num << 8;
		for (int i = 0; i < CORDIC_STAGES; i++) begin
			// Arithmetic shifts on signed longint match floor division by 2^i.
			dx = cy >>> i;
			dy = cx >>> i;
			if (cy >= 0) begin
				cx += dx; cy -= dy; cz += (i < 25) ? tq[i] : 0;
			end else begin
				cx -= dx; cy += dy; cz -= (i < 25) ? tq[i] : 0;
			end
		end
		if (cz <= 0) return 0;
		d = (cz * 9000) / (longint'(157) << 24);
		return (d > 90) ? 90 : int'(d);
	endfunction

	function automatic tilt_t predict_tilt(sample_t s);
		tilt_t t;
		int ax, ay;
		ax = tilt_of(s.x, s.y, s.z);
		ay = tilt_of(s.y, s.x, s.z);
		t.ax = ax[DEG_BITS-1:0];
		t.ay = ay[DEG_BITS-1:0];
		t.x1 = DIG_BITS'(ax % 10); t.x10 = DIG_BITS'((ax / 10) % 10);
		t.x100 = DIG_BITS'((ax / 100) % 10);
		t.x1000 = DIG_BITS'((ax / 1000) % 10);
		t.y1 = DIG_BITS'(ay % 10); t.y10 = DIG_BITS'((ay / 10) % 10);
		t.y100 = DIG_BITS'((ay / 100) % 10);
		t.y1000 = DIG_BITS'((ay / 1000) % 10);
		return t;
	endfunction

	task automatic add_sample(int x, int y, int z);
		sample_t s;
		s.x = MAG_BITS'(x); s.y = MAG_BITS'(y); s.z = MAG_BITS'(z);
		pending_samples.push_back(s);
	endtask

	function automatic int rand_mag();
		case ($urandom_range(0, 9))
			0: return 0;
			1: return $urandom_range(0, 15);
			2: return $urandom_range(2040, 2048);
			3: return $urandom_range(2049, 4095);
			default: return $urandom_range(0, 2048);
		endcase
	endfunction

	// Driver: a transfer happens on the rising edge with start high and busy low.
	always @(negedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				// The item went across; pick the next one or drop start.
				if (pending_samples.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					{x_mag, y_mag, z_mag} <= pending_samples[0];
					expected_tilts.push_back(predict_tilt(pending_samples.pop_front()));
				end else begin
					start <= 1'b0;
				end
			end else if (!start) begin
				if (pending_samples.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					start <= 1'b1;
					{x_mag, y_mag, z_mag} <= pending_samples[0];
					expected_tilts.push_back(predict_tilt(pending_samples.pop_front()));
				end
			end
		end
	end

	// Monitor.
	always @(posedge clk) begin
		tilt_t got, want;
		if (arst_n) begin
			quiet_cycles <= (done || (start && !busy)) ? 0 : quiet_cycles + 1;
			if (done) begin
				got = '{angle_x_deg, angle_y_deg, x_ones, x_tens, x_hundreds, x_thousands,
					y_ones, y_tens, y_hundreds, y_thousands};
				if (expected_tilts.size() == 0) begin
					$display("%0t: unexpected result %h", $realtime, got);
					errors++;
				end else begin
					want = expected_tilts.pop_front();
					if (got !== want) begin
						$display("%0t: mismatch expected ax=%0d ay=%0d digits=%h actual ax=%0d ay=%0d digits=%h",
							$realtime, want.ax, want.ay, want[31:0], got.ax, got.ay, got[31:0]);
						errors++;
					end
				end
			end
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		add_sample(0, 0, 0);
		add_sample(100, 0, 0);
		add_sample(0, 100, 0);
		add_sample(0, 0, 2048);
		add_sample(2048, 2048, 2048);
		add_sample(2048, 0, 0);
		add_sample(1, 2048, 2048);
		add_sample(2048, 1, 0);
		add_sample(4095, 4095, 4095);
		add_sample(4095, 0, 1);
		add_sample(1, 1, 0);
		add_sample(1000, 1000, 0);
		add_sample(0, 500, 500);
		add_sample(1, 0, 0);
		add_sample(2730, 1365, 3003);
		add_sample(1365, 2730, 1092);
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 23 : (ph == 1) ? 78 : 0;
			for (int i = 0; i < 380; i++) add_sample(rand_mag(), rand_mag(), rand_mag());
			while (pending_samples.size() > 0) @(posedge clk);
		end
		while (start) @(posedge clk);
		while (expected_tilts.size() > 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0) $display("TB_OK");
		else $display("TB_ERROR");
		$finish;
	end
endmodule
